@@ rtl/hrm_pkg.sv @@
// ----------------------------------------------------------------------------
// HDR radiance merge package
// Shared widths, configuration and job types, register codes and the gamma
// table builder.
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int MAX_FRAMES   = 4;
  localparam int SLOT_W       = $clog2(MAX_FRAMES);
  localparam int GAMMA_DEPTH  = 1024;
  localparam int GAMMA_IDX_W  = $clog2(GAMMA_DEPTH);
  localparam int SAMPLE_W     = 16;
  localparam int WEIGHT_W     = 17;
  localparam int NUM_W        = 48;
  localparam int DEN_W        = 20;
  localparam int EXP_W        = 24;
  localparam int DVD_W        = 64;
  localparam int DVS_W        = 48;
  localparam int Q_W          = 40;
  localparam int RQ_W         = 47;
  localparam int NUM_SHIFT    = 14;

  localparam logic [SAMPLE_W-1:0] V_HALF   = 16'h8000;
  localparam logic [WEIGHT_W-1:0] W_ONE    = 17'h10000;
  localparam logic [WEIGHT_W-1:0] W_FLOOR  = 17'd7;
  localparam logic [DVD_W-1:0]    Q_MAX    = 64'h0000_0080_0000_0000;
  localparam logic [DVD_W-1:0]    RQ_MAX   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [DVS_W-1:0]    R_ONE    = 48'h0000_4000_0000;
  localparam logic [2:0]          CNT_MAX  = 3'd7;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DEPTH_MODE  = 3'd0,
    REG_FRAME_COUNT = 3'd1,
    REG_EXPOSURE_0  = 3'd2,
    REG_EXPOSURE_1  = 3'd3,
    REG_EXPOSURE_2  = 3'd4,
    REG_EXPOSURE_3  = 3'd5,
    REG_REFERENCE   = 3'd6
  } hrm_reg_t;

  typedef struct packed {
    logic                            depth_mode;
    logic [2:0]                      frame_count;
    logic [MAX_FRAMES-1:0][EXP_W-1:0] exposure;
    logic [EXP_W-1:0]                ref_exp;
  } hrm_cfg_t;

  // one classified frame item, as handed from front to back
  typedef struct packed {
    logic [2:0][SAMPLE_W-1:0] v;
    logic [2:0][WEIGHT_W-1:0] w;
    logic                     acc;
    logic [SLOT_W-1:0]        slot;
    logic                     last;
    logic                     cnt_err;
  } hrm_job_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } hrm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } hrm_div_rsp_t;

  typedef logic [15:0] gamma_rom_t [0:GAMMA_DEPTH];

  // G[i] = largest y with y^11 * D^5 <= i^5 * 65535^11
  function automatic gamma_rom_t gamma_rom_init();
    gamma_rom_t  rom;
    logic [255:0] rhs;
    logic [255:0] lhs;
    int          lo;
    int          hi;
    int          mid;
    for (int i = 0; i <= GAMMA_DEPTH; i++) begin
      rhs = 256'd1;
      for (int k = 0; k < 5; k++) rhs = rhs * 256'(i);
      for (int k = 0; k < 11; k++) rhs = rhs * 256'(65535);
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = 256'd1;
        for (int k = 0; k < 11; k++) lhs = lhs * 256'(mid);
        for (int k = 0; k < 5; k++) lhs = lhs * 256'(GAMMA_DEPTH);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      rom[i] = 16'(lo);
    end
    return rom;
  endfunction

endpackage

@@ rtl/hrm_div.sv @@
// ----------------------------------------------------------------------------
// HDR merge divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrm_div (
  input  logic                  clk,
  input  logic                  rst,
  input  hrm_pkg::hrm_div_req_t req,
  output hrm_pkg::hrm_div_rsp_t rsp
);

  logic                        busy;
  logic [5:0]                  cnt;
  logic [hrm_pkg::DVD_W-1:0]   dvd;
  logic [hrm_pkg::DVS_W-1:0]   dvs;
  logic [hrm_pkg::DVS_W-1:0]   rem;
  logic [hrm_pkg::DVS_W:0]     trial;
  logic [hrm_pkg::DVS_W:0]     diff;
  logic                        ge;
  logic                        done;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, dvd[hrm_pkg::DVD_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // done pulses for one cycle after the final step
      done <= busy && (cnt == 6'(hrm_pkg::DVD_W - 1));
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? diff[hrm_pkg::DVS_W-1:0] : trial[hrm_pkg::DVS_W-1:0];
        dvd <= {dvd[hrm_pkg::DVD_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(hrm_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

@@ rtl/hrm_queue.sv @@
// ----------------------------------------------------------------------------
// HDR merge job queue
// Two-entry FIFO between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module hrm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hrm_pkg::hrm_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output hrm_pkg::hrm_job_t head
);

  hrm_pkg::hrm_job_t entries [0:1];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/hrm_front.sv @@
// ----------------------------------------------------------------------------
// HDR merge front end
// Accepts frame items, normalizes samples, forms hat weights and frame slot.
// ----------------------------------------------------------------------------
module hrm_front (
  input  logic              clk,
  input  logic              rst,
  input  hrm_pkg::hrm_cfg_t cfg,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [15:0]       red_in,
  input  logic [15:0]       green_in,
  input  logic [15:0]       blue_in,
  input  logic              last_frame,
  input  logic              queue_full,
  output logic              push,
  output hrm_pkg::hrm_job_t job
);

  logic [2:0]  frames_seen;
  logic [2:0]  received;
  logic [15:0] raw [0:2];
  logic [15:0] v   [0:2];
  logic [15:0] d   [0:2];
  logic [16:0] w   [0:2];

  assign pixel_stall = queue_full;
  assign push        = pixel_valid && !queue_full;
  assign received    = (frames_seen == hrm_pkg::CNT_MAX) ? hrm_pkg::CNT_MAX
                                                         : frames_seen + 3'd1;

  // sample normalization and hat weight per channel
  always_comb begin
    raw[0] = red_in;
    raw[1] = green_in;
    raw[2] = blue_in;
    for (int c = 0; c < 3; c++) begin
      v[c] = cfg.depth_mode ? raw[c] : {raw[c][7:0], raw[c][7:0]};
      d[c] = (v[c] >= hrm_pkg::V_HALF) ? v[c] - hrm_pkg::V_HALF : hrm_pkg::V_HALF - v[c];
      w[c] = hrm_pkg::W_ONE - {d[c], 1'b0};
      if (w[c] < hrm_pkg::W_FLOOR) w[c] = hrm_pkg::W_FLOOR;
      job.v[c] = v[c];
      job.w[c] = w[c];
    end
    job.acc     = frames_seen < 3'(hrm_pkg::MAX_FRAMES);
    job.slot    = frames_seen[hrm_pkg::SLOT_W-1:0];
    job.last    = last_frame;
    job.cnt_err = received != cfg.frame_count;
  end

  // frame index within the pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen <= '0;
    end else if (push) begin
      frames_seen <= last_frame ? 3'd0 : received;
    end
  end

endmodule

@@ rtl/hrm_back.sv @@
// ----------------------------------------------------------------------------
// HDR merge back end
// Accumulates weighted radiance, then divides, tone maps and applies gamma.
// ----------------------------------------------------------------------------
module hrm_back (
  input  logic              clk,
  input  logic              rst,
  input  hrm_pkg::hrm_cfg_t cfg,
  input  logic              job_valid,
  input  hrm_pkg::hrm_job_t job,
  output logic              job_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [15:0]       red_out,
  output logic [15:0]       green_out,
  output logic [15:0]       blue_out,
  output logic              count_error
);

  localparam hrm_pkg::gamma_rom_t GAMMA_ROM = hrm_pkg::gamma_rom_init();

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC_DIV, ST_ACC_WAIT, ST_Q_DIV, ST_Q_WAIT,
    ST_RQ_LO, ST_RQ_HI, ST_T_DIV, ST_T_WAIT, ST_GAM_RD, ST_GAM_MIX, ST_EMIT
  } state_t;

  state_t                        state;
  hrm_pkg::hrm_job_t             jreg;
  logic [1:0]                    ch;
  logic [hrm_pkg::NUM_W-1:0]     num [0:2];
  logic [hrm_pkg::DEN_W-1:0]     den [0:2];
  logic [32:0]                   prod;
  logic [hrm_pkg::Q_W-1:0]       q;
  logic [55:0]                   mlo;
  logic [hrm_pkg::RQ_W-1:0]      rq;
  logic [15:0]                   t;
  logic [15:0]                   res [0:2];
  logic [15:0]                   rom_a;
  logic [15:0]                   rom_b;
  hrm_pkg::hrm_div_req_t         div_req;
  hrm_pkg::hrm_div_rsp_t         div_rsp;

  logic [hrm_pkg::EXP_W-1:0]     exp_eff;
  logic [hrm_pkg::EXP_W-1:0]     ref_eff;
  logic [hrm_pkg::NUM_W:0]       num_sum;
  logic [hrm_pkg::DEN_W:0]       den_sum;
  logic [31:0]                   mhi;
  logic [63:0]                   rq_sum;
  logic [15+hrm_pkg::GAMMA_IDX_W:0] p;
  logic [hrm_pkg::GAMMA_IDX_W:0] k;
  logic [15:0]                   f;
  logic [31:0]                   mix;

  hrm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // operand selection and datapath terms
  always_comb begin
    exp_eff = (cfg.exposure[jreg.slot] == '0) ? 24'd1 : cfg.exposure[jreg.slot];
    ref_eff = (cfg.ref_exp == '0) ? 24'd1 : cfg.ref_exp;
    num_sum = {1'b0, num[ch]} + 49'(div_rsp.quotient[46:0]);
    den_sum = {1'b0, den[ch]} + 21'(jreg.w[ch]);
    mhi     = 32'(q[39:32]) * 32'(ref_eff);
    rq_sum  = 64'(mlo) + {mhi, 32'b0};
    p       = {t, {hrm_pkg::GAMMA_IDX_W{1'b0}}};
    k       = {1'b0, p[15+hrm_pkg::GAMMA_IDX_W:16]};
    f       = p[15:0];
    mix     = 32'(rom_b - rom_a) * 32'(f);

    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      ST_ACC_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'({prod, {hrm_pkg::NUM_SHIFT{1'b0}}});
        div_req.divisor  = 48'(exp_eff);
      end
      ST_Q_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(num[ch]);
        div_req.divisor  = 48'(den[ch]);
      end
      ST_T_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'({rq, 16'b0});
        div_req.divisor  = 48'(rq) + hrm_pkg::R_ONE;
      end
      default: ;
    endcase
  end

  assign job_pop = (state == ST_IDLE) && job_valid;

  // gamma table, two registered read ports
  always_ff @(posedge clk) begin
    rom_a <= GAMMA_ROM[k];
    rom_b <= GAMMA_ROM[k + 1'b1];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ch           <= '0;
      result_valid <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        num[c] <= '0;
        den[c] <= 20'd1;
      end
    end else begin
      if (result_valid && !result_stall && state != ST_EMIT) result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            jreg <= job;
            ch   <= '0;
            if (job.acc) state <= ST_MUL;
            else if (job.last) state <= ST_Q_DIV;
          end
        end
        ST_MUL: begin
          prod  <= 33'(jreg.v[ch]) * 33'(jreg.w[ch]);
          state <= ST_ACC_DIV;
        end
        ST_ACC_DIV: state <= ST_ACC_WAIT;
        ST_ACC_WAIT: begin
          if (div_rsp.done) begin
            num[ch] <= num_sum[hrm_pkg::NUM_W] ? '1 : num_sum[hrm_pkg::NUM_W-1:0];
            den[ch] <= den_sum[hrm_pkg::DEN_W] ? '1 : den_sum[hrm_pkg::DEN_W-1:0];
            if (ch == 2'd2) begin
              ch    <= '0;
              state <= jreg.last ? ST_Q_DIV : ST_IDLE;
            end else begin
              ch    <= ch + 2'd1;
              state <= ST_MUL;
            end
          end
        end
        ST_Q_DIV: state <= ST_Q_WAIT;
        ST_Q_WAIT: begin
          if (div_rsp.done) begin
            q <= (div_rsp.quotient > hrm_pkg::Q_MAX) ? hrm_pkg::Q_MAX[hrm_pkg::Q_W-1:0]
                                                     : div_rsp.quotient[hrm_pkg::Q_W-1:0];
            state <= ST_RQ_LO;
          end
        end
        ST_RQ_LO: begin
          mlo   <= 56'(q[31:0]) * 56'(ref_eff);
          state <= ST_RQ_HI;
        end
        ST_RQ_HI: begin
          rq    <= (rq_sum > hrm_pkg::RQ_MAX) ? hrm_pkg::RQ_MAX[hrm_pkg::RQ_W-1:0]
                                              : rq_sum[hrm_pkg::RQ_W-1:0];
          state <= ST_T_DIV;
        end
        ST_T_DIV: state <= ST_T_WAIT;
        ST_T_WAIT: begin
          if (div_rsp.done) begin
            t     <= div_rsp.quotient[15:0];
            state <= ST_GAM_RD;
          end
        end
        ST_GAM_RD: state <= ST_GAM_MIX;
        ST_GAM_MIX: begin
          res[ch] <= rom_a + mix[31:16];
          if (ch == 2'd2) begin
            state <= ST_EMIT;
          end else begin
            ch    <= ch + 2'd1;
            state <= ST_Q_DIV;
          end
        end
        ST_EMIT: begin
          if (!result_valid || !result_stall) begin
            red_out      <= res[0];
            green_out    <= res[1];
            blue_out     <= res[2];
            count_error  <= jreg.cnt_err;
            result_valid <= 1'b1;
            for (int c = 0; c < 3; c++) begin
              num[c] <= '0;
              den[c] <= 20'd1;
            end
            ch    <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/hdr_radiance_merge_tonemap.sv @@
// ----------------------------------------------------------------------------
// HDR radiance merge and tone map
// Merges exposure frames per pixel, applies r/(1+r) and gamma 1/2.2.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  pixel    | red_in green_in blue_in last_frame        | pixel_valid / pixel_stall
//  result   | red_out green_out blue_out count_error    | result_valid / result_stall
//  cfg      | cfg_index cfg_data                        | cfg_valid / cfg_ready
//
//  A frame that is accumulated takes one division per channel in the back end, on
//  the shared 64-step divider; a last frame adds two more divisions, the radiance
//  multiply and the gamma lookup per channel.
//  A two-entry queue lets the front accept frames while the back is busy.
//  Reset is synchronous; accumulators return to zero numerator, unit weight.
//  result_stall holds the output register; the back waits only to emit.
// ----------------------------------------------------------------------------
module hdr_radiance_merge_tonemap (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [15:0] red_in,
  input  logic [15:0] green_in,
  input  logic [15:0] blue_in,
  input  logic        last_frame,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] red_out,
  output logic [15:0] green_out,
  output logic [15:0] blue_out,
  output logic        count_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  hrm_pkg::hrm_cfg_t cfg;
  hrm_pkg::hrm_job_t push_job;
  hrm_pkg::hrm_job_t head_job;
  logic              push;
  logic              queue_full;
  logic              job_valid;
  logic              job_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_mode  <= 1'b1;
      cfg.frame_count <= 3'd3;
      cfg.exposure[0] <= 24'd1000;
      cfg.exposure[1] <= 24'd4000;
      cfg.exposure[2] <= 24'd16000;
      cfg.exposure[3] <= 24'd64000;
      cfg.ref_exp     <= 24'd4000;
    end else if (cfg_valid && cfg_ready) begin
      case (hrm_pkg::hrm_reg_t'(cfg_index))
        hrm_pkg::REG_DEPTH_MODE:  cfg.depth_mode  <= cfg_data[0];
        hrm_pkg::REG_FRAME_COUNT: cfg.frame_count <= cfg_data[2:0];
        hrm_pkg::REG_EXPOSURE_0:  cfg.exposure[0] <= cfg_data;
        hrm_pkg::REG_EXPOSURE_1:  cfg.exposure[1] <= cfg_data;
        hrm_pkg::REG_EXPOSURE_2:  cfg.exposure[2] <= cfg_data;
        hrm_pkg::REG_EXPOSURE_3:  cfg.exposure[3] <= cfg_data;
        hrm_pkg::REG_REFERENCE:   cfg.ref_exp     <= cfg_data;
        default: ;
      endcase
    end
  end

  hrm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red_in      (red_in),
    .green_in    (green_in),
    .blue_in     (blue_in),
    .last_frame  (last_frame),
    .queue_full  (queue_full),
    .push        (push),
    .job         (push_job)
  );

  hrm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (job_pop),
    .nonempty (job_valid),
    .head     (head_job)
  );

  hrm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (job_valid),
    .job          (head_job),
    .job_pop      (job_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .count_error  (count_error)
  );

endmodule
